// ===== hdl/sacvb_pkg.sv =====
// ----------------------------------------------------------------------------
// sacvb_pkg
// Shared codes and types of the set-associative cache with victim buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package sacvb_pkg;

    // result kinds
    localparam logic [1:0] KIND_OUTCOME = 2'd0;
    localparam logic [1:0] KIND_WB      = 2'd1;
    localparam logic [1:0] KIND_FETCH   = 2'd2;

    // access outcomes
    localparam logic [1:0] OUT_HIT      = 2'd0;
    localparam logic [1:0] OUT_VHIT     = 2'd1;
    localparam logic [1:0] OUT_MISS     = 2'd2;

    // access commands
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_OFFSET_BITS = 2'd0;
    localparam logic [1:0] CFG_INDEX_BITS  = 2'd1;
    localparam logic [1:0] CFG_WAYS        = 2'd2;
    localparam logic [1:0] CFG_VICTIM      = 2'd3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // victim buffer lookup status
    typedef struct packed {
        logic hit;
        logic hit_dirty;
        logic pick_valid;
        logic pick_dirty;
    } t_vb_stat;

endpackage

`default_nettype wire

// ===== hdl/sacvb_acc_if.sv =====
// ----------------------------------------------------------------------------
// sacvb_acc_if
// Access item channel: command and byte address.
// ----------------------------------------------------------------------------
`default_nettype none

interface sacvb_acc_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] address;

    modport source (output valid, output command, output address, input ready);
    modport sink   (input valid, input command, input address, output ready);
endinterface

`default_nettype wire

// ===== hdl/sacvb_res_if.sv =====
// ----------------------------------------------------------------------------
// sacvb_res_if
// Result item channel: outcome, writeback and fetch requests.
// ----------------------------------------------------------------------------
`default_nettype none

interface sacvb_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [1:0]  outcome;
    logic [31:0] request_address;
    logic        last;

    modport source (output valid, output kind, output outcome, output request_address,
                    output last, input ready);
    modport sink   (input valid, input kind, input outcome, input request_address,
                    input last, output ready);
endinterface

`default_nettype wire

// ===== hdl/set_assoc_cache_with_victim_buffer.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_with_victim_buffer
// Tag-only write-back L1 controller with true LRU and a victim buffer.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  i_acc     in   valid / ready    command, address
//  o_res     out  valid / ready    kind, outcome, request_address, last
//  i_cfg_*   in   write enable     register index, data
//
//  An item is looked up in the cycle after acceptance (set row memory read),
//  the row is written back in that cycle and one to three results follow,
//  one per cycle while the sink is ready. The next item is accepted after
//  the last result is taken.
//  Reset is synchronous; the set rows need no clearing pass.
//  A stalled sink holds the current result and blocks new items.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_cache_with_victim_buffer
    import sacvb_pkg::*;
#(
    parameter int MAX_SETS   = 256,
    parameter int MAX_WAYS   = 8,
    parameter int MAX_VICTIM = 16,
    parameter int ADDR_BITS  = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    sacvb_acc_if.sink                  i_acc,
    sacvb_res_if.source                o_res,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int IDX_MAX = $clog2(MAX_SETS);
    localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WN_W    = $clog2(MAX_WAYS + 1);
    localparam int VIC_W   = (MAX_VICTIM > 1) ? $clog2(MAX_VICTIM) : 1;
    localparam int VN_W    = $clog2(MAX_VICTIM + 1);
    localparam int TAG_W   = ADDR_BITS - 2;
    localparam int META_W  = 2 + WAY_W;
    localparam int TROW_W  = MAX_WAYS * TAG_W;
    localparam int MROW_W  = MAX_WAYS * META_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EVAL = 1'b1;

    // configuration registers
    logic [3:0] r_cfg_ob, r_cfg_ib, r_cfg_nw;
    logic [4:0] r_cfg_nv;
    logic [3:0] ob, ib;
    logic [WN_W-1:0] nw;
    logic [VN_W-1:0] nv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_ob <= 4'd5;
            r_cfg_ib <= 4'd5;
            r_cfg_nw <= 4'd4;
            r_cfg_nv <= 5'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OFFSET_BITS: r_cfg_ob <= i_cfg_data[3:0];
                CFG_INDEX_BITS:  r_cfg_ib <= i_cfg_data[3:0];
                CFG_WAYS:        r_cfg_nw <= i_cfg_data[3:0];
                CFG_VICTIM:      r_cfg_nv <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // saturated settings
    always_comb begin
        ob = (r_cfg_ob < 4'd2) ? 4'd2 : ((r_cfg_ob > 4'd8) ? 4'd8 : r_cfg_ob);
        ib = (r_cfg_ib > 4'(IDX_MAX)) ? 4'(IDX_MAX) : r_cfg_ib;
        if (r_cfg_nw == 4'd0)
            nw = WN_W'(1);
        else if (5'(r_cfg_nw) > 5'(MAX_WAYS))
            nw = WN_W'(MAX_WAYS);
        else
            nw = WN_W'(r_cfg_nw);
        nv = (6'(r_cfg_nv) > 6'(MAX_VICTIM)) ? VN_W'(MAX_VICTIM) : VN_W'(r_cfg_nv);
    end

    // control
    logic r_state, n_state;
    logic acc_fire;
    logic [1:0] r_q_cnt, r_q_head;
    logic [1:0] r_q_kind [3];
    logic [1:0] r_q_outc [3];
    logic [ADDR_BITS-1:0] r_q_addr [3];
    logic [2:0] r_q_last;

    assign i_acc.ready = (r_state == ST_IDLE) && (r_q_cnt == 2'd0);
    assign acc_fire    = i_acc.valid && i_acc.ready;

    // address split at acceptance
    logic [ADDR_BITS-1:0] in_addr, in_blk;
    logic [SET_W-1:0]     in_set;
    logic [ADDR_BITS-1:0] r_blk;
    logic [TAG_W-1:0]     r_tag;
    logic [SET_W-1:0]     r_set;
    logic                 r_wr;

    assign in_addr = ADDR_BITS'({{ADDR_BITS{1'b0}}, i_acc.address});
    assign in_blk  = in_addr >> ob;
    assign in_set  = SET_W'(in_blk) & ~({SET_W{1'b1}} << ib);

    always_ff @(posedge i_clk) begin
        if (acc_fire) begin
            r_blk <= in_blk;
            r_tag <= TAG_W'(in_blk >> ib);
            r_set <= in_set;
            r_wr  <= (i_acc.command == CMD_WRITE);
        end
    end

    // set row memory
    logic [TROW_W-1:0] rd_tag, wr_tag;
    logic [MROW_W-1:0] rd_meta, wr_meta;
    logic              eval;

    assign eval = (r_state == ST_EVAL);

    sacvb_set_mem #(
        .MAX_SETS (MAX_SETS),
        .SET_W    (SET_W),
        .TROW_W   (TROW_W),
        .MROW_W   (MROW_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (acc_fire),
        .i_rd_addr (in_set),
        .i_wr_en   (eval),
        .i_wr_addr (r_set),
        .i_wr_tag  (wr_tag),
        .i_wr_meta (wr_meta),
        .o_rd_tag  (rd_tag),
        .o_rd_meta (rd_meta)
    );

    // victim buffer
    t_vb_stat             vb;
    logic [VIC_W-1:0]     vb_hit_idx, vb_pick_idx, vb_upd_idx;
    logic [ADDR_BITS-1:0] vb_pick_addr;
    logic                 vb_upd_en, vb_upd_valid, vb_upd_dirty;

    // way lookup, replacement and LRU update
    logic [TAG_W-1:0]  t   [MAX_WAYS];
    logic [WAY_W-1:0]  rk  [MAX_WAYS];
    logic [MAX_WAYS-1:0] vld, drt, act, hit_vec, inv_vec, best_vec;
    logic              hit;
    logic [WAY_W-1:0]  hit_w, pick_w, w_sel;
    logic              ov, od, new_dirty;
    logic [WN_W-1:0]   maxr, r_old;
    logic [ADDR_BITS-1:0] oblk;

    always_comb begin
        hit_w  = '0;
        pick_w = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            t[w]       = rd_tag[w*TAG_W +: TAG_W];
            vld[w]     = rd_meta[w*META_W];
            drt[w]     = rd_meta[w*META_W + 1];
            rk[w]      = rd_meta[w*META_W + 2 +: WAY_W];
        end
        for (int w = 0; w < MAX_WAYS; w++) begin
            act[w]     = WN_W'(w) < nw;
            hit_vec[w] = act[w] && vld[w] && (t[w] == r_tag);
            inv_vec[w] = act[w] && !vld[w];
            best_vec[w] = act[w];
            for (int j = 0; j < MAX_WAYS; j++) begin
                if (j < w && WN_W'(j) < nw && !(rk[j] < rk[w]))
                    best_vec[w] = 1'b0;
                if (j > w && WN_W'(j) < nw && rk[j] > rk[w])
                    best_vec[w] = 1'b0;
            end
        end
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (hit_vec[w])
                hit_w = WAY_W'(w);
        end
        if (|inv_vec) begin
            for (int w = MAX_WAYS - 1; w >= 0; w--) begin
                if (inv_vec[w])
                    pick_w = WAY_W'(w);
            end
        end else begin
            for (int w = MAX_WAYS - 1; w >= 0; w--) begin
                if (best_vec[w])
                    pick_w = WAY_W'(w);
            end
        end
    end

    assign hit   = |hit_vec;
    assign w_sel = hit ? hit_w : pick_w;
    assign ov    = vld[w_sel];
    assign od    = drt[w_sel];
    assign oblk  = (ADDR_BITS'({{ADDR_BITS{1'b0}}, t[w_sel]}) << ib)
                 | ADDR_BITS'(r_set);
    assign maxr  = nw - WN_W'(1);
    assign r_old = ov ? WN_W'(rk[w_sel]) : nw;

    always_comb begin
        if (hit)
            new_dirty = od || r_wr;
        else if (vb.hit)
            new_dirty = r_wr || vb.hit_dirty;
        else
            new_dirty = r_wr;
    end

    // row written back
    always_comb begin
        wr_tag  = rd_tag;
        wr_meta = rd_meta;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (WAY_W'(w) == w_sel) begin
                wr_tag[w*TAG_W +: TAG_W]          = r_tag;
                wr_meta[w*META_W]                 = 1'b1;
                wr_meta[w*META_W + 1]             = new_dirty;
                wr_meta[w*META_W + 2 +: WAY_W]    = '0;
            end else if (act[w] && vld[w] && WN_W'(rk[w]) < r_old
                         && WN_W'(rk[w]) < maxr) begin
                wr_meta[w*META_W + 2 +: WAY_W]    = rk[w] + WAY_W'(1);
            end
        end
    end

    // victim buffer update: swap on victim hit, insert on miss eviction
    logic miss, buf_on, wb_req;
    logic [ADDR_BITS-1:0] wb_addr, fetch_addr;

    assign miss   = !hit && !vb.hit;
    assign buf_on = (nv != '0);

    always_comb begin
        vb_upd_en    = 1'b0;
        vb_upd_idx   = vb_pick_idx;
        vb_upd_valid = 1'b1;
        vb_upd_dirty = od;
        wb_req       = 1'b0;
        wb_addr      = oblk << ob;
        if (eval && !hit && vb.hit) begin
            vb_upd_en    = 1'b1;
            vb_upd_idx   = vb_hit_idx;
            vb_upd_valid = ov;
        end else if (eval && miss && ov && buf_on) begin
            vb_upd_en = 1'b1;
            wb_req    = vb.pick_valid && vb.pick_dirty;
            wb_addr   = vb_pick_addr << ob;
        end else if (miss && ov && od) begin
            wb_req    = 1'b1;
        end
    end

    assign fetch_addr = r_blk << ob;

    sacvb_vbuf #(
        .MAX_VICTIM (MAX_VICTIM),
        .ADDR_BITS  (ADDR_BITS),
        .VIC_W      (VIC_W),
        .VN_W       (VN_W)
    ) u_vbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_nv        (nv),
        .i_block     (r_blk),
        .o_stat      (vb),
        .o_hit_idx   (vb_hit_idx),
        .o_pick_idx  (vb_pick_idx),
        .o_pick_addr (vb_pick_addr),
        .i_upd_en    (vb_upd_en),
        .i_upd_idx   (vb_upd_idx),
        .i_upd_addr  (oblk),
        .i_upd_valid (vb_upd_valid),
        .i_upd_dirty (vb_upd_dirty)
    );

    // state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (acc_fire) n_state = ST_EVAL;
            ST_EVAL: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    logic res_fire;
    assign res_fire = o_res.valid && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_q_cnt  <= 2'd0;
            r_q_head <= 2'd0;
        end else begin
            r_state <= n_state;
            if (eval) begin
                r_q_head <= 2'd0;
                r_q_cnt  <= !miss ? 2'd1 : (wb_req ? 2'd3 : 2'd2);
            end else if (res_fire) begin
                if (r_q_head + 2'd1 == r_q_cnt) begin
                    r_q_head <= 2'd0;
                    r_q_cnt  <= 2'd0;
                end else begin
                    r_q_head <= r_q_head + 2'd1;
                end
            end
        end
    end

    // result items of one access
    always_ff @(posedge i_clk) begin
        if (eval) begin
            r_q_kind[0] <= KIND_OUTCOME;
            r_q_outc[0] <= hit ? OUT_HIT : (vb.hit ? OUT_VHIT : OUT_MISS);
            r_q_addr[0] <= '0;
            r_q_last[0] <= !miss;
            r_q_outc[1] <= OUT_MISS;
            r_q_outc[2] <= OUT_MISS;
            r_q_kind[2] <= KIND_FETCH;
            r_q_addr[2] <= fetch_addr;
            r_q_last[2] <= 1'b1;
            if (wb_req) begin
                r_q_kind[1] <= KIND_WB;
                r_q_addr[1] <= wb_addr;
                r_q_last[1] <= 1'b0;
            end else begin
                r_q_kind[1] <= KIND_FETCH;
                r_q_addr[1] <= fetch_addr;
                r_q_last[1] <= 1'b1;
            end
        end
    end

    assign o_res.valid           = (r_q_head < r_q_cnt);
    assign o_res.kind            = r_q_kind[r_q_head];
    assign o_res.outcome         = r_q_outc[r_q_head];
    assign o_res.request_address = 32'({32'b0, r_q_addr[r_q_head]});
    assign o_res.last            = r_q_last[r_q_head];

endmodule

`default_nettype wire

// ===== hdl/sacvb_set_mem.sv =====
// ----------------------------------------------------------------------------
// sacvb_set_mem
// Per-set row memories for tags and way state, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sacvb_set_mem #(
    parameter int MAX_SETS = 256,
    parameter int SET_W    = 8,
    parameter int TROW_W   = 240,
    parameter int MROW_W   = 40
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_rd_en,
    input  wire logic [SET_W-1:0]  i_rd_addr,
    input  wire logic              i_wr_en,
    input  wire logic [SET_W-1:0]  i_wr_addr,
    input  wire logic [TROW_W-1:0] i_wr_tag,
    input  wire logic [MROW_W-1:0] i_wr_meta,
    output logic      [TROW_W-1:0] o_rd_tag,
    output logic      [MROW_W-1:0] o_rd_meta
);

    logic [TROW_W-1:0] mem_tag  [MAX_SETS];
    logic [MROW_W-1:0] mem_meta [MAX_SETS];
    logic [MAX_SETS-1:0] r_row_ok;
    logic [TROW_W-1:0] r_rd_tag;
    logic [MROW_W-1:0] r_rd_meta;
    logic              r_rd_ok;

    // row memories
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_tag[i_wr_addr]  <= i_wr_tag;
            mem_meta[i_wr_addr] <= i_wr_meta;
        end
        if (i_rd_en) begin
            r_rd_tag  <= mem_tag[i_rd_addr];
            r_rd_meta <= mem_meta[i_rd_addr];
            r_rd_ok   <= r_row_ok[i_rd_addr];
        end
    end

    // rows never written read as all ways invalid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_ok <= '0;
        end else if (i_wr_en) begin
            r_row_ok[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_tag  = r_rd_tag;
    assign o_rd_meta = r_rd_ok ? r_rd_meta : '0;

endmodule

`default_nettype wire

// ===== hdl/sacvb_vbuf.sv =====
// ----------------------------------------------------------------------------
// sacvb_vbuf
// Fully associative victim buffer: lookup, replacement pick, LRU update.
// ----------------------------------------------------------------------------
`default_nettype none

module sacvb_vbuf
    import sacvb_pkg::*;
#(
    parameter int MAX_VICTIM = 16,
    parameter int ADDR_BITS  = 32,
    parameter int VIC_W      = 4,
    parameter int VN_W       = 5
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [VN_W-1:0]      i_nv,
    input  wire logic [ADDR_BITS-1:0] i_block,
    output t_vb_stat                  o_stat,
    output logic      [VIC_W-1:0]     o_hit_idx,
    output logic      [VIC_W-1:0]     o_pick_idx,
    output logic      [ADDR_BITS-1:0] o_pick_addr,
    input  wire logic                 i_upd_en,
    input  wire logic [VIC_W-1:0]     i_upd_idx,
    input  wire logic [ADDR_BITS-1:0] i_upd_addr,
    input  wire logic                 i_upd_valid,
    input  wire logic                 i_upd_dirty
);

    logic [ADDR_BITS-1:0] r_addr [MAX_VICTIM];
    logic [MAX_VICTIM-1:0] r_vld, r_drt;
    logic [VIC_W-1:0]     r_rank [MAX_VICTIM];

    logic [MAX_VICTIM-1:0] act, hit_vec, inv_vec, best_vec;
    logic [VN_W-1:0]       maxr, r_old;

    // lookup and replacement choice
    always_comb begin
        o_hit_idx  = '0;
        o_pick_idx = '0;
        for (int k = 0; k < MAX_VICTIM; k++) begin
            act[k]     = VN_W'(k) < i_nv;
            hit_vec[k] = act[k] && r_vld[k] && (r_addr[k] == i_block);
            inv_vec[k] = act[k] && !r_vld[k];
            best_vec[k] = act[k];
            for (int j = 0; j < MAX_VICTIM; j++) begin
                if (j < k && VN_W'(j) < i_nv && !(r_rank[j] < r_rank[k]))
                    best_vec[k] = 1'b0;
                if (j > k && VN_W'(j) < i_nv && r_rank[j] > r_rank[k])
                    best_vec[k] = 1'b0;
            end
        end
        for (int k = MAX_VICTIM - 1; k >= 0; k--) begin
            if (hit_vec[k])
                o_hit_idx = VIC_W'(k);
        end
        if (|inv_vec) begin
            for (int k = MAX_VICTIM - 1; k >= 0; k--) begin
                if (inv_vec[k])
                    o_pick_idx = VIC_W'(k);
            end
        end else begin
            for (int k = MAX_VICTIM - 1; k >= 0; k--) begin
                if (best_vec[k])
                    o_pick_idx = VIC_W'(k);
            end
        end
    end

    assign o_stat.hit        = |hit_vec;
    assign o_stat.hit_dirty  = r_drt[o_hit_idx];
    assign o_stat.pick_valid = r_vld[o_pick_idx];
    assign o_stat.pick_dirty = r_drt[o_pick_idx];
    assign o_pick_addr       = r_addr[o_pick_idx];

    // promotion bound for the updated entry
    assign maxr  = i_nv - VN_W'(1);
    assign r_old = r_vld[i_upd_idx] ? VN_W'(r_rank[i_upd_idx]) : i_nv;

    // entry payload
    always_ff @(posedge i_clk) begin
        if (i_upd_en)
            r_addr[i_upd_idx] <= i_upd_addr;
    end

    // valid, dirty and LRU ranks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_drt <= '0;
            for (int k = 0; k < MAX_VICTIM; k++)
                r_rank[k] <= '0;
        end else if (i_upd_en) begin
            r_vld[i_upd_idx] <= i_upd_valid;
            r_drt[i_upd_idx] <= i_upd_dirty;
            for (int k = 0; k < MAX_VICTIM; k++) begin
                if (VIC_W'(k) == i_upd_idx)
                    r_rank[k] <= '0;
                else if (act[k] && r_vld[k] && VN_W'(r_rank[k]) < r_old
                         && VN_W'(r_rank[k]) < maxr)
                    r_rank[k] <= r_rank[k] + VIC_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sacvb_checker.sv =====
// ----------------------------------------------------------------------------
// sacvb_checker
// Port-level checks of the cache controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sacvb_checker
    import sacvb_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_acc_valid,
    input wire logic        i_acc_ready,
    input wire logic        i_res_valid,
    input wire logic        i_res_ready,
    input wire logic [1:0]  i_res_kind,
    input wire logic [1:0]  i_res_outcome,
    input wire logic        i_res_last
);

    // a shown result stays until taken
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped while stalled");

    // no new item while results are pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> !i_acc_ready)
        else $error("item accepted with results pending");

    // an accepted item is looked up before the next one
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_acc_valid && i_acc_ready |=> !i_acc_ready)
        else $error("back to back acceptance");

    // fetch closes the access
    a_fetch_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_kind == KIND_FETCH |-> i_res_last)
        else $error("fetch not last");

    // requests only come from misses
    a_req_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_kind != KIND_OUTCOME |-> i_res_outcome == OUT_MISS)
        else $error("request without miss");

endmodule

bind set_assoc_cache_with_victim_buffer sacvb_checker u_sacvb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_acc_valid   (i_acc.valid),
    .i_acc_ready   (i_acc.ready),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_res_kind    (o_res.kind),
    .i_res_outcome (o_res.outcome),
    .i_res_last    (o_res.last)
);

`default_nettype wire
